### src/value_noise_fbm_pixel_top_defines.svh
// Shared assertion macros.
`ifndef VALUE_NOISE_FBM_PIXEL_TOP_DEFINES_SVH
`define VALUE_NOISE_FBM_PIXEL_TOP_DEFINES_SVH

// Plain property, sampled on clk_i, off while in reset.
`define VNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication into the next cycle.
`define VNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vnf_pkg.sv
`timescale 1ns / 1ps
package vnf_pkg;

  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned LAT_W   = 8;
  localparam int unsigned COORD_W = FRAC_W + LAT_W;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned OCT_W   = 4;

  localparam logic [16:0] W_ONE = 17'h10000;

  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_PIXEL = 1'b1;

  localparam logic [1:0] CFG_BASE_FREQ = 2'd0;
  localparam logic [1:0] CFG_OCTAVES   = 2'd1;
  localparam logic [1:0] CFG_SEED      = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COORD,
    ST_READ,
    ST_BLEND_X,
    ST_BLEND_Y,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SHAPE1,
    ST_SHAPE2,
    ST_SHAPE3
  } state_e;

endpackage

### src/vnf_fade.sv
`timescale 1ns / 1ps
// Quintic fade 6t^5-15t^4+10t^3 of a 12-bit fraction, Q0.16 out, 4 stages.
module vnf_fade (
  input  logic        clk_i,
  input  logic [11:0] frac_i,
  output logic [15:0] fade_o
);

  logic [11:0] f_q;
  logic [23:0] f2_q;
  logic [35:0] f3_q;
  logic [27:0] poly_q;
  logic [49:0] pl_q;
  logic [49:0] ph_q;
  logic [15:0] fade_q;

  logic [29:0] poly_w;
  logic [50:0] acc_w;

  assign poly_w = 30'(f2_q) * 30'd6 + 30'd167772160 - 30'(f_q) * 30'd61440;
  assign acc_w  = {1'b0, ph_q} + 51'(pl_q >> 14);

  always_ff @(posedge clk_i) begin
    f_q    <= frac_i;
    f2_q   <= frac_i * frac_i;
    f3_q   <= f2_q * f_q;
    poly_q <= poly_w[27:0];
    pl_q   <= f3_q * poly_q[13:0];
    ph_q   <= f3_q * poly_q[27:14];
    fade_q <= acc_w[45:30];
  end

  assign fade_o = fade_q;

endmodule

### src/vnf_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step: one quotient bit, remainder handed on.
module vnf_div_cell #(
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [DW-1:0] d_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [QW-1:0] quo_i,
  output logic          vld_o,
  output logic [DW-1:0] d_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] low_o,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;
  logic          vld_q;
  logic [DW-1:0] d_q, rem_q;
  logic [QW-1:0] low_q, quo_q;

  assign r2   = {rem_i, low_i[QW-1]};
  assign ge   = r2 >= {1'b0, d_i};
  assign diff = r2 - {1'b0, d_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_i;
    rem_q <= ge ? diff[DW-1:0] : r2[DW-1:0];
    low_q <= {low_i[QW-2:0], 1'b0};
    quo_q <= {quo_i[QW-2:0], ge};
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;
  assign rem_o = rem_q;
  assign low_o = low_q;
  assign quo_o = quo_q;

endmodule

### src/value_noise_fbm_pixel_top.sv
`timescale 1ns / 1ps
// Value-noise fBm pixel generator.
// Slave stream: tuser = kind (0 load table entry, 1 compute pixel); tdata
// carries entry_index, entry_value, pixel_x, pixel_y. Load transfers write one
// permutation table entry in the transfer cycle and produce nothing. A pixel
// transfer produces one gray_level on the master stream.
// Config port: cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while idle
// (the block does not enforce this): 0 base_frequency, 1 octave_count, 2 hash_seed.
// Only one pixel is in flight at a time: a new pixel is not taken until the last
// one has been loaded into the output register.
// Each octave walks the single table read port through six dependent
// lookups; the final normalization goes through a 16-cell restoring divider
// chain, one quotient bit per cell.
// tready is high only while idle; load transfers can stream one per cycle.
// Reset empties the output register, returns to idle and loads register
// defaults (205, 4, 0); the table itself is not cleared.
// A stalled receiver holds the result in the output register; the next pixel
// is still accepted and waits in its last step until the register frees.
`include "value_noise_fbm_pixel_top_defines.svh"
module value_noise_fbm_pixel_top #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] entry_index, [15:8] entry_value, [27:16] pixel_x, [39:28] pixel_y
  input  logic [39:0] s_axis_tdata_i,
  // [0] kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] gray_level
  output logic [7:0]  m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned DW = MAX_OCTAVES;
  localparam int unsigned SW = vnf_pkg::VAL_W + MAX_OCTAVES;
  localparam int unsigned QW = vnf_pkg::QUO_W;

  vnf_pkg::state_e state_q, state_d;

  logic [15:0] base_q;
  logic [3:0]  octs_q;
  logic [7:0]  seed_q;

  logic [7:0]  mem [256];
  logic [7:0]  rdata_q;
  logic [7:0]  raddr;
  logic        mem_we;

  logic        s_acc;
  logic        div_go;
  logic        out_load;

  logic [11:0] px_q, py_q;
  logic [3:0]  k_q, oct_q;
  logic [2:0]  rs_q;
  logic [19:0] cx_q, cy_q;
  logic [7:0]  first0_q, first1_q;
  logic [7:0]  c00_q, c10_q, c01_q, c11_q;
  logic [15:0] wx, wy;
  logic [23:0] lo_q, hi_q, val_q;
  logic [SW-1:0] sum_q;
  logic [15:0] n16_q, m2_q, m4_q;
  logic        out_vld_q;
  logic [7:0]  out_q;

  logic [4:0]  k_w;
  logic [19:0] fq;
  logic [31:0] cxm, cym;
  logic [16:0] ix, iy;
  logic [24:0] lo_w, hi_w;
  logic [40:0] blend_w;
  logic [SW-1:0] sum_add;
  logic [16:0] dmask;
  logic [15:0] m_w;
  logic [31:0] m2_w, m4_w;
  logic [23:0] g_w;
  logic [SW-9:0] s8;

  logic [QW:0]   ch_vld;
  logic [DW-1:0] ch_d   [QW+1];
  logic [DW-1:0] ch_rem [QW+1];
  logic [QW-1:0] ch_low [QW+1];
  logic [QW-1:0] ch_quo [QW+1];

  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign mem_we = s_acc && (s_axis_tuser_i == vnf_pkg::KIND_LOAD);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vnf_pkg::ST_IDLE:
        if (s_acc && (s_axis_tuser_i == vnf_pkg::KIND_PIXEL)) state_d = vnf_pkg::ST_COORD;
      vnf_pkg::ST_COORD:    state_d = vnf_pkg::ST_READ;
      vnf_pkg::ST_READ:     if (rs_q == 3'd6) state_d = vnf_pkg::ST_BLEND_X;
      vnf_pkg::ST_BLEND_X:  state_d = vnf_pkg::ST_BLEND_Y;
      vnf_pkg::ST_BLEND_Y:  state_d = vnf_pkg::ST_ACCUM;
      vnf_pkg::ST_ACCUM:
        state_d = (oct_q == k_q - 4'd1) ? vnf_pkg::ST_DIV_GO : vnf_pkg::ST_COORD;
      vnf_pkg::ST_DIV_GO:   state_d = vnf_pkg::ST_DIV_WAIT;
      vnf_pkg::ST_DIV_WAIT: if (ch_vld[QW]) state_d = vnf_pkg::ST_SHAPE1;
      vnf_pkg::ST_SHAPE1:   state_d = vnf_pkg::ST_SHAPE2;
      vnf_pkg::ST_SHAPE2:   state_d = vnf_pkg::ST_SHAPE3;
      vnf_pkg::ST_SHAPE3:
        if (!out_vld_q || m_axis_tready_i) state_d = vnf_pkg::ST_IDLE;
      default:              state_d = vnf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = (state_q == vnf_pkg::ST_IDLE);
    div_go          = (state_q == vnf_pkg::ST_DIV_GO);
    out_load        = (state_q == vnf_pkg::ST_SHAPE3) && (!out_vld_q || m_axis_tready_i);
    unique case (rs_q)
      3'd0:    raddr = cy_q[19:12] + seed_q;
      3'd1:    raddr = cy_q[19:12] + 8'd1 + seed_q;
      3'd2:    raddr = first0_q + cx_q[19:12];
      3'd3:    raddr = first0_q + cx_q[19:12] + 8'd1;
      3'd4:    raddr = first1_q + cx_q[19:12];
      3'd5:    raddr = first1_q + cx_q[19:12] + 8'd1;
      default: raddr = first1_q + cx_q[19:12] + 8'd1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s_axis_tdata_i[7:0]] <= s_axis_tdata_i[15:8];
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vnf_pkg::ST_IDLE;
      base_q    <= 16'd205;
      octs_q    <= 4'd4;
      seed_q    <= 8'd0;
      rs_q      <= 3'd0;
      oct_q     <= 4'd0;
      k_q       <= 4'd1;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vnf_pkg::CFG_BASE_FREQ: base_q <= cfg_data_i;
          vnf_pkg::CFG_OCTAVES:   octs_q <= cfg_data_i[3:0];
          vnf_pkg::CFG_SEED:      seed_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (state_q == vnf_pkg::ST_IDLE) begin
        oct_q <= 4'd0;
        k_q   <= k_w[3:0];
      end else if (state_q == vnf_pkg::ST_ACCUM) begin
        oct_q <= oct_q + 4'd1;
      end
      rs_q <= (state_q == vnf_pkg::ST_READ) ? rs_q + 3'd1 : 3'd0;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign k_w = (octs_q == 4'd0) ? 5'd1 :
               ({1'b0, octs_q} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, octs_q};

  assign fq   = 20'({4'd0, base_q} << oct_q);
  assign cxm  = px_q * fq;
  assign cym  = py_q * fq;
  assign ix   = vnf_pkg::W_ONE - {1'b0, wx};
  assign iy   = vnf_pkg::W_ONE - {1'b0, wy};
  assign lo_w = c00_q * ix + c10_q * {1'b0, wx};
  assign hi_w = c01_q * ix + c11_q * {1'b0, wx};
  assign blend_w = lo_q * iy + hi_q * {1'b0, wy};
  assign sum_add = SW'(val_q) << (k_q - 4'd1 - oct_q);
  assign dmask   = (17'd1 << k_q) - 17'd1;
  assign s8      = sum_q[SW-1:8];
  assign m_w     = {1'b1, n16_q[15:1]};
  assign m2_w    = m_w * m_w;
  assign m4_w    = m2_q * m2_q;
  assign g_w     = m4_q * 8'd255;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      px_q  <= s_axis_tdata_i[27:16];
      py_q  <= s_axis_tdata_i[39:28];
      sum_q <= '0;
    end
    if (state_q == vnf_pkg::ST_COORD) begin
      cx_q <= cxm[19:0];
      cy_q <= cym[19:0];
    end
    if (state_q == vnf_pkg::ST_READ) begin
      unique case (rs_q)
        3'd1:    first0_q <= rdata_q;
        3'd2:    first1_q <= rdata_q;
        3'd3:    c00_q    <= rdata_q;
        3'd4:    c10_q    <= rdata_q;
        3'd5:    c01_q    <= rdata_q;
        3'd6:    c11_q    <= rdata_q;
        default: ;
      endcase
    end
    if (state_q == vnf_pkg::ST_BLEND_X) begin
      lo_q <= lo_w[23:0];
      hi_q <= hi_w[23:0];
    end
    if (state_q == vnf_pkg::ST_BLEND_Y) begin
      val_q <= blend_w[39:16];
    end
    if (state_q == vnf_pkg::ST_ACCUM) begin
      sum_q <= sum_q + sum_add;
    end
    if (ch_vld[QW]) begin
      n16_q <= ch_quo[QW];
    end
    m2_q <= m2_w[31:16];
    m4_q <= m4_w[31:16];
    if (out_load) begin
      out_q <= g_w[23:16];
    end
  end

  vnf_fade u_fade_x (.clk_i(clk_i), .frac_i(cx_q[11:0]), .fade_o(wx));
  vnf_fade u_fade_y (.clk_i(clk_i), .frac_i(cy_q[11:0]), .fade_o(wy));

  // divider chain: sum/256 over 2^K-1
  assign ch_vld[0] = div_go;
  assign ch_d[0]   = dmask[DW-1:0];
  assign ch_rem[0] = s8[SW-9:QW];
  assign ch_low[0] = s8[QW-1:0];
  assign ch_quo[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    vnf_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (ch_vld[g]),
      .d_i   (ch_d[g]),
      .rem_i (ch_rem[g]),
      .low_i (ch_low[g]),
      .quo_i (ch_quo[g]),
      .vld_o (ch_vld[g+1]),
      .d_o   (ch_d[g+1]),
      .rem_o (ch_rem[g+1]),
      .low_o (ch_low[g+1]),
      .quo_o (ch_quo[g+1])
    );
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  `VNF_ASSERT(a_div_single, $onehot0(ch_vld), "more than one division in flight")
  `VNF_ASSERT(a_div_when_waiting, !ch_vld[QW] || (state_q == vnf_pkg::ST_DIV_WAIT),
              "quotient outside wait")
  `VNF_ASSERT(a_oct_range, (state_q != vnf_pkg::ST_ACCUM) || (oct_q < k_q),
              "octave index past count")
  `VNF_ASSERT_NEXT(a_pixel_busy, s_acc && (s_axis_tuser_i == vnf_pkg::KIND_PIXEL),
                   !s_axis_tready_o, "ready right after pixel transfer")

endmodule

### test/tb_value_noise_fbm_pixel_top.sv
`timescale 1ns / 1ps
module tb_value_noise_fbm_pixel_top;

  typedef struct {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [11:0] px;
    logic [11:0] py;
  } noise_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  value_noise_fbm_pixel_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  noise_item_t pending_q[$];
  logic [7:0]  gray_expected_q[$];
  logic [7:0]  perm_copy[256];
  logic [15:0] base_freq_r = 16'd205;
  logic [3:0]  octaves_r = 4'd4;
  logic [7:0]  seed_r = 8'd0;
  int          mismatches = 0;
  int          results_seen = 0;
  bit          no_idle = 1'b0;

  function automatic longint unsigned fade_q16(longint unsigned f);
    longint unsigned poly;
    poly = 6 * f * f + 10 * 4096 * 4096 - 15 * 4096 * f;
    return (f * f * f * poly) >> 44;
  endfunction

  function automatic longint unsigned corner_val(longint unsigned cx, longint unsigned cy);
    logic [7:0] first;
    first = perm_copy[8'(cy + seed_r)];
    return perm_copy[8'(first + cx)];
  endfunction

  function automatic longint unsigned octave_val(longint unsigned cx, longint unsigned cy);
    longint unsigned xi, yi, wx, wy, lo, hi;
    xi = (cx >> 12) & 255;
    yi = (cy >> 12) & 255;
    wx = fade_q16(cx & 12'hFFF);
    wy = fade_q16(cy & 12'hFFF);
    lo = corner_val(xi, yi) * (65536 - wx) + corner_val(xi + 1, yi) * wx;
    hi = corner_val(xi, yi + 1) * (65536 - wx) + corner_val(xi + 1, yi + 1) * wx;
    return (lo * (65536 - wy) + hi * wy) >> 16;
  endfunction

  function automatic logic [7:0] gray_for_pixel(logic [11:0] px, logic [11:0] py);
    longint unsigned k, sum, f, divisor, n16, m, m2, m4;
    k = octaves_r;
    if (k < 1) k = 1;
    if (k > 8) k = 8;
    sum = 0;
    for (int i = 0; i < k; i++) begin
      f = longint'(base_freq_r) << i;
      sum += octave_val(px * f, py * f) << (k - 1 - i);
    end
    divisor = (longint'(256) << 16) * ((longint'(1) << k) - 1);
    n16 = (sum << 16) / divisor;
    if (n16 > 65535) n16 = 65535;
    m = (n16 + 65536) >> 1;
    m2 = (m * m) >> 16;
    m4 = (m2 * m2) >> 16;
    return 8'((m4 * 255) >> 16);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    noise_item_t it;
    logic nv;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      nv = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        it = pending_q.pop_front();
        if (it.kind == vnf_pkg::KIND_LOAD) perm_copy[it.idx] = it.val;
        else gray_expected_q.push_back(gray_for_pixel(it.px, it.py));
        nv = 1'b0;
        tx_gap = pick_gap();
      end
      if (!nv) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_q.size() > 0) begin
          nv = 1'b1;
          it = pending_q[0];
          s_axis_tdata_i <= {it.py, it.px, it.val, it.idx};
          s_axis_tuser_i <= it.kind;
        end
      end
      s_axis_tvalid_i <= nv;
    end
  end

  // monitor
  int rx_gap = 0;
  int rx_hold = 0;
  bit hold_done = 1'b0;
  int cycles = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    logic nr;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      cycles++;
      if (cycles > 3000000) begin
        $display("Mismatches found");
        $finish;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (gray_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected gray level %0d", m_axis_tdata_o);
        end else begin
          want = gray_expected_q.pop_front();
          if (want !== m_axis_tdata_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("gray level: expected %0d, got %0d", want, m_axis_tdata_o);
          end
        end
        rx_gap = pick_gap();
      end
      if (!hold_done && results_seen == 120) begin
        hold_done = 1'b1;
        rx_hold = 4000;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nr = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nr = 1'b0;
      end else nr = ($urandom_range(0, 9) != 0) || no_idle;
      m_axis_tready_i <= nr;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid_i || gray_expected_q.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vnf_pkg::CFG_BASE_FREQ: base_freq_r = data;
      vnf_pkg::CFG_OCTAVES:   octaves_r = data[3:0];
      vnf_pkg::CFG_SEED:      seed_r = data[7:0];
      default: ;
    endcase
  endtask

  task automatic push_load(logic [7:0] idx, logic [7:0] val);
    noise_item_t it;
    it.kind = vnf_pkg::KIND_LOAD;
    it.idx = idx;
    it.val = val;
    it.px = 12'($urandom);
    it.py = 12'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic push_pixel(logic [11:0] px, logic [11:0] py);
    noise_item_t it;
    it.kind = vnf_pkg::KIND_PIXEL;
    it.idx = 8'($urandom);
    it.val = 8'($urandom);
    it.px = px;
    it.py = py;
    pending_q.push_back(it);
  endtask

  function automatic logic [11:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(0, 63));
      default: return 12'($urandom);
    endcase
  endfunction

  logic [15:0] freq_set[6] = '{16'd205, 16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd0};
  logic [15:0] oct_set[6]  = '{16'd4, 16'd1, 16'd8, 16'd0, 16'hF, 16'd3};
  logic [15:0] seed_set[6] = '{16'd0, 16'hFF, 16'd17, 16'd3, 16'd128, 16'd0};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 256; i++) push_load(8'(i), 8'($urandom));
    push_load(8'd0, 8'hFF);
    push_load(8'hFF, 8'd0);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'hFFF, 12'hFFF);
    push_pixel(12'hFFF, 12'd0);
    push_pixel(12'd0, 12'hFFF);
    push_pixel(12'd1234, 12'd2345);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        if (ph == 5) begin
          freq_set[5] = 16'($urandom);
          seed_set[5] = 16'($urandom);
        end
        write_reg(vnf_pkg::CFG_BASE_FREQ, freq_set[ph]);
        write_reg(vnf_pkg::CFG_OCTAVES, oct_set[ph]);
        write_reg(vnf_pkg::CFG_SEED, seed_set[ph]);
        write_reg(2'd3, 16'($urandom));
      end
      no_idle = (ph == 2);
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(0, 4) == 0) push_load(8'($urandom), 8'($urandom));
        else push_pixel(rand_coord(), rand_coord());
      end
    end
    wait_drained();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
